// ===== src/hci_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hci_pkg
// Shared codes and state types for the chained hash index unit.
// ----------------------------------------------------------------------------
package hci_pkg;

    localparam int KEY_W     = 32;
    localparam int IN_VAL_W  = 32;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_W     = 9;
    localparam int USED_W    = 9;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 48;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_NO_POOL = 2'd2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_HEAD,
        B_CHECK,
        B_ENT,
        B_EXEC,
        B_POP,
        B_ALLOC
    } t_back_state;

endpackage
`default_nettype wire

// ===== src/hci_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hci_front
// Accepts requests and derives the bucket by a bit-serial restoring modulo.
// ----------------------------------------------------------------------------
module hci_front #(
    parameter int CW    = 9,
    parameter int BKT_W = 8,
    parameter int PL_W  = 74
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [hci_pkg::ACT_W-1:0] i_action,
    input  wire logic [hci_pkg::KEY_W-1:0] i_key,
    input  wire logic [hci_pkg::IN_VAL_W-1:0] i_value,
    input  wire logic [CW-1:0]             i_mod,
    input  wire logic                      i_hold,
    output logic                           o_valid,
    input  wire logic                      i_q_ready,
    output logic [PL_W-1:0]                o_payload
);
    import hci_pkg::*;

    t_front_state          r_state, n_state;
    logic [ACT_W-1:0]      r_act;
    logic [KEY_W-1:0]      r_key;
    logic [IN_VAL_W-1:0]   r_val;
    logic [KEY_W-1:0]      r_mag, n_mag;
    logic [CW-1:0]         r_rem, n_rem;
    logic [4:0]            r_cnt, n_cnt;
    logic [CW:0]           trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        if (i_valid && o_ready) begin
            r_act <= i_action;
            r_key <= i_key;
            r_val <= i_value;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        o_ready = 1'b0;
        o_valid = 1'b0;
        trial   = {r_rem, r_mag[KEY_W-1]};
        case (r_state)
            F_IDLE: begin
                o_ready = !i_hold;
                if (i_valid && !i_hold) begin
                    // magnitude as unsigned: the most negative key stays 2^31
                    n_mag   = i_key[KEY_W-1] ? (~i_key + 1'b1) : i_key;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                n_rem = (trial >= {1'b0, i_mod}) ? CW'(trial - {1'b0, i_mod}) : CW'(trial);
                n_mag = {r_mag[KEY_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                o_valid = 1'b1;
                if (i_q_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign o_payload = {r_rem[BKT_W-1:0], r_val, r_key, r_act};

endmodule
`default_nettype wire

// ===== src/hci_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hci_queue
// Two-entry request queue between the front and the back end.
// ----------------------------------------------------------------------------
module hci_queue #(
    parameter int PL_W = 74
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_not_full,
    input  wire logic [PL_W-1:0] i_data,
    input  wire logic            i_pop,
    output logic                 o_not_empty,
    output logic [PL_W-1:0]      o_data
);
    import hci_pkg::*;

    logic [PL_W-1:0] r_slot [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            do_push, do_pop;

    assign o_not_full  = (r_cnt != 2'd2);
    assign o_not_empty = (r_cnt != 2'd0);
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;
    assign o_data      = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/hci_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hci_back
// Walks the bucket chain in the entry pool and applies the request.
// ----------------------------------------------------------------------------
module hci_back #(
    parameter int BUCKETS      = 256,
    parameter int POOL_ENTRIES = 512,
    parameter int VALUE_BITS   = 32,
    parameter int CW           = 9,
    parameter int BKT_W        = 8,
    parameter int PL_W         = 74
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_not_empty,
    input  wire logic [PL_W-1:0] i_q_data,
    output logic                 o_q_pop,
    input  wire logic [CW-1:0]   i_mod,
    output logic                 o_clearing,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output logic [hci_pkg::OUT_DATA_W-1:0] o_data
);
    import hci_pkg::*;

    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam int EW = $clog2(POOL_ENTRIES);
    localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

    // storage
    logic [LW-1:0]         head_mem  [BUCKETS];
    logic [KEY_W-1:0]      key_mem   [POOL_ENTRIES];
    logic [VALUE_BITS-1:0] val_mem   [POOL_ENTRIES];
    logic [LW-1:0]         link_mem  [POOL_ENTRIES];
    logic [EW-1:0]         stk_mem   [POOL_ENTRIES];

    logic [LW-1:0]         head_q, link_q;
    logic [KEY_W-1:0]      key_q;
    logic [VALUE_BITS-1:0] val_q;
    logic [EW-1:0]         stk_q;

    logic                  head_we, head_re, ent_re, key_we, val_we, link_we, stk_we, stk_re;
    logic [BKT_W-1:0]      head_wa;
    logic [LW-1:0]         head_wd, link_wd;
    logic [EW-1:0]         ent_ra, key_wa, val_wa, link_wa, stk_wa, stk_ra, stk_wd;
    logic [VALUE_BITS-1:0] val_wd;

    t_back_state           r_state, n_state;
    logic [ACT_W-1:0]      r_act;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [BKT_W-1:0]      r_bkt, r_clr;
    logic [LW-1:0]         r_head, n_head, r_cur, n_cur, r_prev, n_prev;
    logic [LW-1:0]         r_steps, n_steps, r_fc, n_fc, r_low, n_low;
    logic [CW-1:0]         r_occ, n_occ;
    logic                  r_out_valid, n_out_valid;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [IN_VAL_W-1:0]   r_found, n_found;
    logic                  r_full, n_full;
    logic [USED_W-1:0]     r_used, n_used;

    logic [63:0]           in_val64, found64;
    logic [31:0]           occ32;
    logic [EW-1:0]         top_pos, new_ent;

    assign in_val64 = 64'(i_q_data[ACT_W+KEY_W +: IN_VAL_W]);
    assign found64  = 64'(val_q);
    assign top_pos  = EW'(r_fc - 1'b1);
    // below the low-water mark the stack was never written, so the entry is derived
    assign new_ent  = (r_fc - 1'b1 < r_low) ? EW'(POOL_ENTRIES - 1) - top_pos : stk_q;

    always_ff @(posedge i_clk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        if (head_re) head_q <= head_mem[r_bkt];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[key_wa] <= r_key;
        if (val_we) val_mem[val_wa] <= val_wd;
        if (link_we) link_mem[link_wa] <= link_wd;
        if (ent_re) begin
            key_q  <= key_mem[ent_ra];
            val_q  <= val_mem[ent_ra];
            link_q <= link_mem[ent_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) stk_mem[stk_wa] <= stk_wd;
        if (stk_re) stk_q <= stk_mem[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr       <= '0;
            r_fc        <= LW'(POOL_ENTRIES);
            r_low       <= LW'(POOL_ENTRIES);
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= r_clr + 1'b1;
            r_fc        <= n_fc;
            r_low       <= n_low;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_act <= i_q_data[ACT_W-1:0];
            r_key <= i_q_data[ACT_W +: KEY_W];
            r_val <= in_val64[VALUE_BITS-1:0];
            r_bkt <= i_q_data[ACT_W+KEY_W+IN_VAL_W +: BKT_W];
        end
        r_head   <= n_head;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_found  <= n_found;
        r_used   <= n_used;
        r_full   <= n_full;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_steps     = r_steps;
        n_fc        = r_fc;
        n_low       = r_low;
        n_occ       = r_occ;
        n_out_valid = r_out_valid && !i_ready;
        n_status    = r_status;
        n_found     = r_found;
        n_used      = r_used;
        n_full      = r_full;
        o_q_pop     = 1'b0;
        head_we = 1'b0; head_wa = r_bkt; head_wd = NIL; head_re = 1'b0;
        ent_re  = 1'b0; ent_ra  = r_cur[EW-1:0];
        key_we  = 1'b0; key_wa  = new_ent;
        val_we  = 1'b0; val_wa  = r_cur[EW-1:0]; val_wd = r_val;
        link_we = 1'b0; link_wa = new_ent; link_wd = r_head;
        stk_we  = 1'b0; stk_wa  = r_fc[EW-1:0]; stk_wd = r_cur[EW-1:0];
        stk_re  = 1'b0; stk_ra  = top_pos;
        occ32   = '0;
        case (r_state)
            B_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                if (r_clr == BKT_W'(BUCKETS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (i_q_not_empty && (!r_out_valid || i_ready)) begin
                    o_q_pop = 1'b1;
                    n_state = B_HEAD;
                end
            end
            B_HEAD: begin
                head_re = 1'b1;
                n_steps = '0;
                n_prev  = NIL;
                n_state = B_CHECK;
            end
            B_CHECK: begin
                if (r_steps == '0) begin
                    n_head = head_q;
                end
                if ((r_steps == '0 ? head_q : r_cur) < NIL && r_steps != NIL) begin
                    ent_ra  = (r_steps == '0) ? head_q[EW-1:0] : r_cur[EW-1:0];
                    ent_re  = 1'b1;
                    n_cur   = (r_steps == '0) ? head_q : r_cur;
                    n_state = B_ENT;
                end else begin
                    n_cur   = NIL;
                    n_state = B_EXEC;
                end
            end
            B_ENT: begin
                if (key_q == r_key) begin
                    n_state = B_EXEC;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = link_q;
                    n_steps = r_steps + 1'b1;
                    // a step count of zero marks the head read, so skip it
                    n_state = B_CHECK;
                    if (n_steps == '0) n_steps = NIL;
                end
            end
            B_EXEC: begin
                n_status = ST_MISSING;
                n_found  = '0;
                n_state  = B_IDLE;
                case (r_act)
                    ACT_INSERT: begin
                        if (r_cur < NIL) begin
                            val_we   = 1'b1;
                            n_status = ST_DONE;
                        end else if (r_fc == '0) begin
                            n_status = ST_NO_POOL;
                        end else begin
                            stk_re  = 1'b1;
                            n_state = B_POP;
                        end
                    end
                    ACT_LOOKUP: begin
                        if (r_cur < NIL) begin
                            n_found  = found64[IN_VAL_W-1:0];
                            n_status = ST_DONE;
                        end
                    end
                    ACT_REMOVE: begin
                        if (r_cur < NIL) begin
                            if (r_prev < NIL) begin
                                link_we = 1'b1;
                                link_wa = r_prev[EW-1:0];
                                link_wd = link_q;
                            end else begin
                                head_we = 1'b1;
                                head_wd = link_q;
                                if (!(link_q < NIL) && r_occ != '0) begin
                                    n_occ = r_occ - 1'b1;
                                end
                            end
                            if (r_fc < NIL) begin
                                stk_we = 1'b1;
                                n_fc   = r_fc + 1'b1;
                            end
                            n_status = ST_DONE;
                        end
                    end
                    default: begin
                        n_status = ST_MISSING;
                    end
                endcase
                if (n_state == B_IDLE) begin
                    n_out_valid = 1'b1;
                end
            end
            B_POP: begin
                n_state = B_ALLOC;
            end
            B_ALLOC: begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                val_wa  = new_ent;
                link_we = 1'b1;
                head_we = 1'b1;
                head_wd = LW'(new_ent);
                if (!(r_head < NIL)) begin
                    n_occ = r_occ + 1'b1;
                end
                n_fc = r_fc - 1'b1;
                if (r_fc - 1'b1 < r_low) begin
                    n_low = r_fc - 1'b1;
                end
                n_status    = ST_DONE;
                n_found     = '0;
                n_out_valid = 1'b1;
                n_state     = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        occ32  = 32'(n_occ);
        n_used = occ32[USED_W-1:0];
        n_full = (n_occ >= i_mod);
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_data     = {4'b0, r_full, r_used, r_found, r_status};

endmodule
`default_nettype wire

// ===== src/chained_hash_index_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_index_unit
// Key-to-value index as a separately chained hash table over an entry pool.
// ----------------------------------------------------------------------------
// One request (insert/update, lookup, remove) gives one result. The front
// end takes the bit-serial modulo of |key| by the configured bucket count
// and passes the request with its bucket to the queue. The back end then
// reads the bucket head and walks the chain to the entry that holds the key.
// Each step is one registered read of the entry pool memories. Inserts of a
// new key add a read of the free stack. The front end computes the next
// bucket while the back end walks a chain. After reset the bucket head
// memory is swept, during which no request is taken.
// ----------------------------------------------------------------------------
module chained_hash_index_unit #(
    parameter int BUCKETS      = 256,
    parameter int POOL_ENTRIES = 512,
    parameter int VALUE_BITS   = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // action[1:0], key[33:2], value[65:34], zero fill
    input  wire logic [hci_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // status[1:0], found_value[33:2], buckets_used[42:34], full_res[43], zero fill
    output logic [hci_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [hci_pkg::CFG_W-1:0] i_cfg_wdata
);
    import hci_pkg::*;

    localparam int CW    = $clog2(BUCKETS + 1);
    localparam int BKT_W = $clog2(BUCKETS);
    localparam int PL_W  = ACT_W + KEY_W + IN_VAL_W + BKT_W;

    logic [CFG_W-1:0] r_cfg;
    logic [CW-1:0]    mod_eff;
    logic             clearing, f_valid, q_not_full, q_not_empty, q_pop;
    logic [PL_W-1:0]  f_payload, q_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(256);
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // clamp the divisor into 1..BUCKETS
    always_comb begin
        if (r_cfg == '0) begin
            mod_eff = CW'(1);
        end else if (32'(r_cfg) > 32'(BUCKETS)) begin
            mod_eff = CW'(BUCKETS);
        end else begin
            mod_eff = CW'(r_cfg);
        end
    end

    hci_front #(.CW(CW), .BKT_W(BKT_W), .PL_W(PL_W)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_action  (i_s_axis_tdata[1:0]),
        .i_key     (i_s_axis_tdata[33:2]),
        .i_value   (i_s_axis_tdata[65:34]),
        .i_mod     (mod_eff),
        .i_hold    (clearing),
        .o_valid   (f_valid),
        .i_q_ready (q_not_full),
        .o_payload (f_payload)
    );

    hci_queue #(.PL_W(PL_W)) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_valid),
        .o_not_full  (q_not_full),
        .i_data      (f_payload),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_data      (q_data)
    );

    hci_back #(
        .BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES), .VALUE_BITS(VALUE_BITS),
        .CW(CW), .BKT_W(BKT_W), .PL_W(PL_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_q_data      (q_data),
        .o_q_pop       (q_pop),
        .i_mod         (mod_eff),
        .o_clearing    (clearing),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_data        (o_m_axis_tdata)
    );

endmodule
`default_nettype wire
